// File: rtl/i2cm_pkg.sv
// Shared types, codes and sizes of the I2C master transaction engine.
`default_nettype none

package i2cm_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int CNT_W        = 5;
  localparam int IDX_W        = 5;

  localparam logic [6:0] DEV_ADDR_RESET    = 7'd80;
  localparam logic [4:0] RETRY_RESET       = 5'd5;
  localparam logic [4:0] PROBE_RETRY_RESET = 5'd16;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PUSH  = 2'd1,
    FUNC_START = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR    = 2'd0,
    CFG_RETRY       = 2'd1,
    CFG_PROBE_RETRY = 2'd2
  } cfg_idx_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_START = 8'b0000_0010,
    PH_TX    = 8'b0000_0100,
    PH_CHK   = 8'b0000_1000,
    PH_STOP  = 8'b0001_0000,
    PH_RXPRE = 8'b0010_0000,
    PH_RX    = 8'b0100_0000,
    PH_MACK  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       operation;
    logic             wide_address;
    logic [15:0]      register_address;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       write_byte;
    logic             sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic       failed;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_byte;
  } res_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [4:0] retry_limit;
    logic [4:0] probe_retry_limit;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/i2cm_if.sv
// Channel interfaces: command/tick items, result items and register writes.
`default_nettype none

interface i2cm_item_if;
  import i2cm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [1:0]       operation;
  logic             wide_address;
  logic [15:0]      register_address;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       write_byte;
  logic             sda_sample;

  modport source (
    output valid, func, operation, wide_address, register_address, byte_count,
           write_byte, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, func, operation, wide_address, register_address, byte_count,
           write_byte, sda_sample,
    output ready
  );
endinterface

interface i2cm_result_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_released;
  logic       busy_res;
  logic       done_res;
  logic       failed;
  logic [7:0] read_data;
  logic       read_valid;
  logic       last_byte;

  modport source (
    output valid, scl_level, sda_level, sda_released, busy_res, done_res, failed,
           read_data, read_valid, last_byte,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_released, busy_res, done_res, failed,
           read_data, read_valid, last_byte,
    output ready
  );
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/i2c_master_transaction_engine.sv
// I2C master transaction engine: top level with register port and result register.
//
// One item is taken per clock cycle and each item gives exactly one result in the next
// cycle, held in a single result register; the item channel stays ready while that
// register is empty or being drained in the same cycle, so the rate is one item per
// cycle whenever the result sink is ready. Items push write bytes (up to 16), start a
// write, read or address probe, or act as bus ticks: each tick moves SCL/SDA by one
// delay segment and carries the SDA level sampled during it. A missing acknowledge
// ends the attempt with a stop and restarts the whole transaction until the retry
// limit is used up, then done comes with failed set. Registers: 0 device address,
// 1 retry limit, 2 probe retry limit; write them only while no transaction is busy.
`default_nettype none

module i2c_master_transaction_engine (
  input wire logic     clk,
  input wire logic     rst,
  i2cm_item_if.sink    item,
  i2cm_result_if.source result,
  i2cm_cfg_if.sink     cfg
);
  import i2cm_pkg::*;

  cfg_t  cfg_q;
  item_t item_in;
  res_t  res_comb;
  res_t  res_q;
  logic  out_valid;
  logic  step;

  assign item.ready = !out_valid || result.ready;
  assign step       = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign item_in = '{
    func:             item.func,
    operation:        item.operation,
    wide_address:     item.wide_address,
    register_address: item.register_address,
    byte_count:       item.byte_count,
    write_byte:       item.write_byte,
    sda_sample:       item.sda_sample
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.device_address    <= DEV_ADDR_RESET;
      cfg_q.retry_limit       <= RETRY_RESET;
      cfg_q.probe_retry_limit <= PROBE_RETRY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DEV_ADDR:    cfg_q.device_address    <= cfg.data;
        CFG_RETRY:       cfg_q.retry_limit       <= cfg.data[4:0];
        CFG_PROBE_RETRY: cfg_q.probe_retry_limit <= cfg.data[4:0];
        default: begin
        end
      endcase
    end
  end

  i2cm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item_in),
    .cfg  (cfg_q),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_comb;
    end
  end

  assign result.valid        = out_valid;
  assign result.scl_level    = res_q.scl_level;
  assign result.sda_level    = res_q.sda_level;
  assign result.sda_released = res_q.sda_released;
  assign result.busy_res     = res_q.busy_res;
  assign result.done_res     = res_q.done_res;
  assign result.failed       = res_q.failed;
  assign result.read_data    = res_q.read_data;
  assign result.read_valid   = res_q.read_valid;
  assign result.last_byte    = res_q.last_byte;

endmodule

`default_nettype wire

// File: rtl/i2cm_core.sv
// Bus sequencer: command latch, write buffer and per-tick SCL/SDA segment logic.
`default_nettype none

module i2cm_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire i2cm_pkg::item_t item,
  input  wire i2cm_pkg::cfg_t  cfg,
  output i2cm_pkg::res_t      res
);
  import i2cm_pkg::*;

  phase_t            phase, phase_next;
  logic [1:0]        seg, seg_next;
  logic [2:0]        bit_index, bit_index_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [4:0]        attempt, attempt_next;
  logic [7:0]        shift, shift_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [15:0]       cmd_reg, cmd_reg_next;
  logic [CNT_W-1:0]  cmd_cnt, cmd_cnt_next;
  logic [1:0]        cmd_op, cmd_op_next;
  logic              cmd_wide, cmd_wide_next;
  logic              nack, nack_next;
  logic              scl_q, scl_next;
  logic              sda_q, sda_next;

  logic [7:0]        wbuf [BUFFER_DEPTH];
  logic              buf_we;
  logic [7:0]        wbuf_q;

  logic [IDX_W-1:0]  na;
  logic [CNT_W-1:0]  wlen, rlen;
  logic [IDX_W-1:0]  bi1, slot, boff, rd_off;
  logic [7:0]        slot_byte;
  logic              last;
  logic [4:0]        lim, att1;

  // Slot count: device address, one or two register bytes, then data or read address.
  assign na   = cmd_wide ? IDX_W'(2) : IDX_W'(1);
  assign wlen = (cmd_cnt > CNT_W'(BUFFER_DEPTH)) ? CNT_W'(BUFFER_DEPTH) : cmd_cnt;
  assign rlen = (wlen == '0) ? CNT_W'(1) : wlen;
  assign bi1  = byte_index + IDX_W'(1);
  assign last = ({1'b0, byte_index} + 6'd1) >= {1'b0, rlen};

  // The check phase hands over to the next slot, the start phase to the current one.
  assign slot = (phase == PH_CHK) ? bi1 : byte_index;
  assign boff = slot - na - IDX_W'(1);

  // Buffer data is only loaded from the check phase, which lasts several ticks with
  // byte_index held, so the byte for the following slot is fetched ahead of time.
  assign rd_off = bi1 - na - IDX_W'(1);

  always_comb begin
    if (cmd_op == OP_PROBE) begin
      slot_byte = {cmd_reg[6:0], 1'b0};
    end else if (slot == '0) begin
      slot_byte = {cfg.device_address, 1'b0};
    end else if (slot <= na) begin
      slot_byte = (cmd_wide && slot == IDX_W'(1)) ? cmd_reg[15:8] : cmd_reg[7:0];
    end else if (cmd_op == OP_READ) begin
      slot_byte = {cfg.device_address, 1'b1};
    end else if ({1'b0, boff} < 6'(BUFFER_DEPTH)) begin
      slot_byte = wbuf_q;
    end else begin
      slot_byte = '0;
    end
  end

  assign lim  = (cmd_op == OP_PROBE) ?
                ((cfg.probe_retry_limit == '0) ? 5'd1 : cfg.probe_retry_limit) :
                ((cfg.retry_limit == '0) ? 5'd1 : cfg.retry_limit);
  assign att1 = attempt + 5'd1;

  always_comb begin
    phase_next      = phase;
    seg_next        = seg;
    bit_index_next  = bit_index;
    byte_index_next = byte_index;
    attempt_next    = attempt;
    shift_next      = shift;
    fill_next       = fill;
    cmd_reg_next    = cmd_reg;
    cmd_cnt_next    = cmd_cnt;
    cmd_op_next     = cmd_op;
    cmd_wide_next   = cmd_wide;
    nack_next       = nack;
    scl_next        = scl_q;
    sda_next        = sda_q;
    buf_we          = 1'b0;
    res             = '0;
    res.scl_level   = scl_q;
    res.sda_level   = sda_q;

    case (item.func)
      FUNC_PUSH: begin
        if (phase == PH_IDLE && fill < FILL_W'(BUFFER_DEPTH)) begin
          buf_we    = 1'b1;
          fill_next = fill + FILL_W'(1);
        end
      end
      FUNC_START: begin
        if (phase == PH_IDLE && item.operation != 2'd3) begin
          cmd_reg_next    = item.register_address;
          cmd_cnt_next    = item.byte_count;
          cmd_op_next     = item.operation;
          cmd_wide_next   = item.wide_address;
          fill_next       = '0;
          attempt_next    = '0;
          byte_index_next = '0;
          bit_index_next  = '0;
          seg_next        = '0;
          nack_next       = 1'b0;
          phase_next      = PH_START;
        end
      end
      FUNC_TICK: begin
        case (phase)
          PH_START: begin
            if (seg == 2'd0) begin
              scl_next = 1'b1;
              sda_next = 1'b1;
            end else if (seg == 2'd1) begin
              sda_next = 1'b0;
            end else begin
              scl_next = 1'b0;
            end
            res.scl_level = scl_next;
            res.sda_level = sda_next;
            if (seg < 2'd2) begin
              seg_next = seg + 2'd1;
            end else begin
              shift_next     = slot_byte;
              bit_index_next = '0;
              seg_next       = '0;
              phase_next     = PH_TX;
            end
          end
          PH_TX: begin
            if (seg == 2'd0) begin
              scl_next = 1'b0;
            end else if (seg == 2'd1) begin
              sda_next = shift[3'd7 - bit_index];
            end else begin
              scl_next = 1'b1;
            end
            res.scl_level = scl_next;
            res.sda_level = sda_next;
            if (seg < 2'd2) begin
              seg_next = seg + 2'd1;
            end else begin
              seg_next = '0;
              if (bit_index < 3'd7) begin
                bit_index_next = bit_index + 3'd1;
              end else begin
                // drop SCL after the segment is reported
                scl_next   = 1'b0;
                phase_next = PH_CHK;
              end
            end
          end
          PH_CHK: begin
            if (seg == 2'd0) begin
              scl_next         = 1'b0;
              sda_next         = 1'b1;
              res.sda_released = 1'b1;
            end else if (seg == 2'd1) begin
              scl_next         = 1'b1;
              res.sda_released = 1'b1;
              nack_next        = item.sda_sample;
            end else if (seg == 2'd2) begin
              scl_next         = 1'b0;
              res.sda_released = 1'b1;
            end
            res.scl_level = scl_next;
            res.sda_level = sda_next;
            if (seg < 2'd3) begin
              seg_next = seg + 2'd1;
            end else begin
              seg_next = '0;
              if (nack || cmd_op == OP_PROBE) begin
                phase_next = PH_STOP;
              end else begin
                byte_index_next = bi1;
                if (cmd_op == OP_WRITE) begin
                  if ({1'b0, bi1} < 6'd1 + {1'b0, na} + {1'b0, wlen}) begin
                    shift_next     = slot_byte;
                    bit_index_next = '0;
                    phase_next     = PH_TX;
                  end else begin
                    phase_next = PH_STOP;
                  end
                end else if (bi1 <= na) begin
                  shift_next     = slot_byte;
                  bit_index_next = '0;
                  phase_next     = PH_TX;
                end else if (bi1 == na + IDX_W'(1)) begin
                  // repeated start before the read address
                  phase_next = PH_START;
                end else begin
                  byte_index_next = '0;
                  phase_next      = PH_RXPRE;
                end
              end
            end
          end
          PH_STOP: begin
            if (seg == 2'd0) begin
              scl_next = 1'b0;
              sda_next = 1'b0;
            end else if (seg == 2'd1) begin
              scl_next = 1'b1;
            end else begin
              sda_next = 1'b1;
            end
            res.scl_level = scl_next;
            res.sda_level = sda_next;
            if (seg < 2'd2) begin
              seg_next = seg + 2'd1;
            end else begin
              seg_next  = '0;
              nack_next = 1'b0;
              if (nack) begin
                attempt_next = att1;
                if (att1 < lim) begin
                  byte_index_next = '0;
                  phase_next      = PH_START;
                end else begin
                  res.failed   = 1'b1;
                  res.done_res = 1'b1;
                  phase_next   = PH_IDLE;
                end
              end else begin
                res.done_res = 1'b1;
                phase_next   = PH_IDLE;
              end
            end
          end
          PH_RXPRE: begin
            scl_next         = 1'b0;
            res.scl_level    = 1'b0;
            res.sda_released = 1'b1;
            shift_next       = '0;
            bit_index_next   = '0;
            seg_next         = '0;
            phase_next       = PH_RX;
          end
          PH_RX: begin
            if (seg == 2'd0) begin
              scl_next   = 1'b1;
              shift_next = {shift[6:0], item.sda_sample};
            end else if (seg == 2'd2) begin
              scl_next = 1'b0;
            end
            res.scl_level    = scl_next;
            res.sda_released = 1'b1;
            if (seg < 2'd2) begin
              seg_next = seg + 2'd1;
            end else begin
              seg_next = '0;
              if (bit_index < 3'd7) begin
                bit_index_next = bit_index + 3'd1;
              end else begin
                sda_next   = 1'b1;
                phase_next = PH_MACK;
              end
            end
          end
          PH_MACK: begin
            if (seg == 2'd0) begin
              sda_next = last;
            end else if (seg == 2'd1) begin
              scl_next = 1'b1;
            end else begin
              scl_next = 1'b0;
            end
            res.scl_level = scl_next;
            res.sda_level = sda_next;
            if (seg < 2'd2) begin
              seg_next = seg + 2'd1;
            end else begin
              seg_next       = '0;
              res.read_data  = shift;
              res.read_valid = 1'b1;
              res.last_byte  = last;
              sda_next       = 1'b1;
              if (last) begin
                nack_next  = 1'b0;
                phase_next = PH_STOP;
              end else begin
                byte_index_next = bi1;
                phase_next      = PH_RXPRE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      seg        <= '0;
      bit_index  <= '0;
      byte_index <= '0;
      attempt    <= '0;
      shift      <= '0;
      fill       <= '0;
      cmd_reg    <= '0;
      cmd_cnt    <= '0;
      cmd_op     <= OP_WRITE;
      cmd_wide   <= 1'b0;
      nack       <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      seg        <= seg_next;
      bit_index  <= bit_index_next;
      byte_index <= byte_index_next;
      attempt    <= attempt_next;
      shift      <= shift_next;
      fill       <= fill_next;
      cmd_reg    <= cmd_reg_next;
      cmd_cnt    <= cmd_cnt_next;
      cmd_op     <= cmd_op_next;
      cmd_wide   <= cmd_wide_next;
      nack       <= nack_next;
      scl_q      <= scl_next;
      sda_q      <= sda_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && buf_we) begin
      wbuf[fill[BUF_AW-1:0]] <= item.write_byte;
    end
    wbuf_q <= wbuf[rd_off[BUF_AW-1:0]];
  end

endmodule

`default_nettype wire

// File: rtl/i2cm_checker.sv
// Port-level checks on the result channel of the I2C master engine, with its bind.
`default_nettype none

module i2cm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       scl_level,
  input wire logic       sda_level,
  input wire logic       sda_released,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic       failed,
  input wire logic [7:0] read_data,
  input wire logic       read_valid,
  input wire logic       last_byte
);

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(done_res)
      && $stable(scl_level) && $stable(sda_level))
    else $error("result changed while stalled");

  // a finished transaction leaves the engine idle
  assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && failed |-> done_res)
    else $error("failure reported without done");

  // a byte is handed out on the low-clock segment closing its ack
  assert property (@(posedge clk) disable iff (rst)
    res_valid && last_byte |-> read_valid && !scl_level)
    else $error("last byte flag without a received byte");

  // the line is never driven low while the master listens
  assert property (@(posedge clk) disable iff (rst)
    res_valid && sda_released |-> sda_level)
    else $error("SDA driven low while released");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .scl_level    (result.scl_level),
  .sda_level    (result.sda_level),
  .sda_released (result.sda_released),
  .busy_res     (result.busy_res),
  .done_res     (result.done_res),
  .failed       (result.failed),
  .read_data    (result.read_data),
  .read_valid   (result.read_valid),
  .last_byte    (result.last_byte)
);

`default_nettype wire
